// ===== src/modexp_pkg.sv =====
package modexp_pkg;

  // widths fixed by the port definition
  localparam int DATA_W            = 32;
  localparam int DEFAULT_WORD_BITS = 32;
  localparam logic [DATA_W-1:0] RESET_MODULUS = 32'd3329;

  // microcode step counter
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // datapath actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_LOAD   = 3'd1;
  localparam logic [2:0] ACT_MUL    = 3'd2;
  localparam logic [2:0] ACT_RSTART = 3'd3;
  localparam logic [2:0] ACT_DONE   = 3'd4;

  // reduction result destinations
  localparam logic [1:0] DEST_NONE = 2'd0;
  localparam logic [1:0] DEST_ACC  = 2'd1;
  localparam logic [1:0] DEST_BASE = 2'd2;

  // jump conditions
  localparam logic [2:0] COND_NEVER    = 3'd0;
  localparam logic [2:0] COND_ALWAYS   = 3'd1;
  localparam logic [2:0] COND_NSTART   = 3'd2;
  localparam logic [2:0] COND_NDONE    = 3'd3;
  localparam logic [2:0] COND_EZERO    = 3'd4;
  localparam logic [2:0] COND_EBIT_CLR = 3'd5;

  // program addresses
  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_INIT_MUL  = 4'd1;
  localparam step_t STEP_INIT_RED  = 4'd2;
  localparam step_t STEP_INIT_WAIT = 4'd3;
  localparam step_t STEP_TEST      = 4'd4;
  localparam step_t STEP_BIT       = 4'd5;
  localparam step_t STEP_ACC_MUL   = 4'd6;
  localparam step_t STEP_ACC_RED   = 4'd7;
  localparam step_t STEP_ACC_WAIT  = 4'd8;
  localparam step_t STEP_SQ_MUL    = 4'd9;
  localparam step_t STEP_SQ_RED    = 4'd10;
  localparam step_t STEP_SQ_WAIT   = 4'd11;
  localparam step_t STEP_LOOP      = 4'd12;
  localparam step_t STEP_DONE      = 4'd13;

  typedef struct packed {
    logic [2:0] act;
    logic       sel_acc;  // multiplier operand a: acc, else base
    logic       sel_one;  // multiplier operand b: one, else base
    logic [1:0] dest;
    logic       shift_e;
    logic [2:0] cond;
    step_t      target;
  } ctl_t;

  typedef struct packed {
    logic e_zero;
    logic e_bit0;
    logic red_done;
  } stat_t;

  function automatic ctl_t cw(input logic [2:0] act, input logic sel_acc,
                              input logic sel_one, input logic [1:0] dest,
                              input logic shift_e, input logic [2:0] cond,
                              input step_t target);
    ctl_t c;
    c.act     = act;
    c.sel_acc = sel_acc;
    c.sel_one = sel_one;
    c.dest    = dest;
    c.shift_e = shift_e;
    c.cond    = cond;
    c.target  = target;
    return c;
  endfunction

  // control store
  function automatic ctl_t microcode(input step_t pc);
    ctl_t c;
    unique case (pc)
      STEP_IDLE:      c = cw(ACT_LOAD,   1'b0, 1'b0, DEST_NONE, 1'b0, COND_NSTART, STEP_IDLE);
      STEP_INIT_MUL:  c = cw(ACT_MUL,    1'b0, 1'b1, DEST_NONE, 1'b0, COND_NEVER, STEP_IDLE);
      STEP_INIT_RED:  c = cw(ACT_RSTART, 1'b0, 1'b0, DEST_NONE, 1'b0, COND_NEVER, STEP_IDLE);
      STEP_INIT_WAIT: c = cw(ACT_NONE,   1'b0, 1'b0, DEST_BASE, 1'b0, COND_NDONE,
                             STEP_INIT_WAIT);
      STEP_TEST:      c = cw(ACT_NONE,   1'b0, 1'b0, DEST_NONE, 1'b0, COND_EZERO, STEP_DONE);
      STEP_BIT:       c = cw(ACT_NONE,   1'b0, 1'b0, DEST_NONE, 1'b0, COND_EBIT_CLR,
                             STEP_SQ_MUL);
      STEP_ACC_MUL:   c = cw(ACT_MUL,    1'b1, 1'b0, DEST_NONE, 1'b0, COND_NEVER, STEP_IDLE);
      STEP_ACC_RED:   c = cw(ACT_RSTART, 1'b0, 1'b0, DEST_NONE, 1'b0, COND_NEVER, STEP_IDLE);
      STEP_ACC_WAIT:  c = cw(ACT_NONE,   1'b0, 1'b0, DEST_ACC,  1'b0, COND_NDONE,
                             STEP_ACC_WAIT);
      STEP_SQ_MUL:    c = cw(ACT_MUL,    1'b0, 1'b0, DEST_NONE, 1'b1, COND_NEVER, STEP_IDLE);
      STEP_SQ_RED:    c = cw(ACT_RSTART, 1'b0, 1'b0, DEST_NONE, 1'b0, COND_NEVER, STEP_IDLE);
      STEP_SQ_WAIT:   c = cw(ACT_NONE,   1'b0, 1'b0, DEST_BASE, 1'b0, COND_NDONE,
                             STEP_SQ_WAIT);
      STEP_LOOP:      c = cw(ACT_NONE,   1'b0, 1'b0, DEST_NONE, 1'b0, COND_ALWAYS, STEP_TEST);
      STEP_DONE:      c = cw(ACT_DONE,   1'b0, 1'b0, DEST_NONE, 1'b0, COND_ALWAYS, STEP_IDLE);
      default:        c = cw(ACT_NONE,   1'b0, 1'b0, DEST_NONE, 1'b0, COND_ALWAYS, STEP_IDLE);
    endcase
    return c;
  endfunction

endpackage

// ===== src/modexp_reduce.sv =====
module modexp_reduce #(
  parameter int WORD_BITS = modexp_pkg::DEFAULT_WORD_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2*WORD_BITS-1:0]   x,
  input  logic [WORD_BITS-1:0]     m,
  output logic                     done,
  output logic [WORD_BITS-1:0]     r
);

  localparam int CNT_W = $clog2(WORD_BITS + 1);

  logic [2*WORD_BITS-1:0] xs;
  logic [WORD_BITS-1:0]   rem;
  logic [CNT_W-1:0]       cnt;
  logic                   run;
  logic                   done_q;

  logic [WORD_BITS:0]   mx, s1, d1, s2, d2;
  logic [WORD_BITS-1:0] r1, r2;

  // two restoring remainder steps a cycle; a zero modulus degrades to a shift
  always_comb begin
    mx = {1'b0, m};
    s1 = {rem, xs[2*WORD_BITS-1]};
    d1 = s1 - mx;
    r1 = (s1 >= mx) ? d1[WORD_BITS-1:0] : s1[WORD_BITS-1:0];
    s2 = {r1, xs[2*WORD_BITS-2]};
    d2 = s2 - mx;
    r2 = (s2 >= mx) ? d2[WORD_BITS-1:0] : s2[WORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= run && (cnt == CNT_W'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(WORD_BITS);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs  <= x;
      rem <= '0;
    end else if (run) begin
      xs  <= {xs[2*WORD_BITS-3:0], 2'b00};
      rem <= r2;
    end
  end

  assign done = done_q;
  assign r    = rem;

endmodule

// ===== src/modexp_datapath.sv =====
module modexp_datapath #(
  parameter int WORD_BITS = modexp_pkg::DEFAULT_WORD_BITS
) (
  input  logic                              clk,
  input  logic                              start,
  input  logic [modexp_pkg::DATA_W-1:0]     base,
  input  logic [modexp_pkg::DATA_W-1:0]     exponent,
  input  logic [modexp_pkg::DATA_W-1:0]     modulus,
  input  modexp_pkg::ctl_t                  ctl,
  input  logic                              red_done,
  input  logic [WORD_BITS-1:0]              red_r,
  output logic [2*WORD_BITS-1:0]            prod,
  output logic [WORD_BITS-1:0]              m,
  output modexp_pkg::stat_t                 stat,
  output logic [modexp_pkg::DATA_W-1:0]     power_result
);

  import modexp_pkg::*;

  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] b;
  logic [WORD_BITS-1:0] e;
  logic [WORD_BITS-1:0] op_a, op_b;

  assign op_a = ctl.sel_acc ? acc : b;
  assign op_b = ctl.sel_one ? WORD_BITS'(1) : b;

  always_ff @(posedge clk) begin
    if (ctl.act == ACT_LOAD && start) begin
      m   <= modulus[WORD_BITS-1:0];
      b   <= base[WORD_BITS-1:0];
      e   <= exponent[WORD_BITS-1:0];
      acc <= WORD_BITS'(1);
    end else begin
      if (ctl.act == ACT_MUL) begin
        prod <= op_a * op_b;
      end
      if (ctl.shift_e) begin
        e <= e >> 1;
      end
      if (red_done && ctl.dest == DEST_ACC) begin
        acc <= red_r;
      end
      if (red_done && ctl.dest == DEST_BASE) begin
        b <= red_r;
      end
    end
  end

  assign stat.e_zero   = (e == '0);
  assign stat.e_bit0   = e[0];
  assign stat.red_done = red_done;
  assign power_result  = DATA_W'(acc);

endmodule

// ===== src/modexp_sequencer.sv =====
module modexp_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  modexp_pkg::stat_t stat,
  output modexp_pkg::ctl_t  ctl,
  output logic              busy,
  output logic              done
);

  import modexp_pkg::*;

  step_t pc;
  step_t pc_next;
  logic  take;

  assign ctl = microcode(pc);

  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NSTART:   take = !start;
      COND_NDONE:    take = !stat.red_done;
      COND_EZERO:    take = stat.e_zero;
      COND_EBIT_CLR: take = !stat.e_bit0;
      default:       take = 1'b1;
    endcase
    pc_next = take ? ctl.target : pc + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign busy = (pc != STEP_IDLE);
  assign done = (ctl.act == ACT_DONE);

endmodule

// ===== src/modular_exponentiation.sv =====
// modular exponentiation, base ** exponent mod modulus, right-to-left
// square-and-multiply. pulse start while busy is low to hand in one beat of
// base and exponent; busy rises on the next cycle and stays high until the
// result has gone out. power_result is valid for exactly the one cycle in
// which done is high, and the receiver cannot hold it off, so it must take
// the beat then. the base is reduced first, the accumulator starts at one and
// is only ever replaced by reduced products, so a zero exponent returns one
// for every modulus. only the low WORD_BITS bits of base, exponent and the
// modulus take part. the base is reduced first; then every exponent bit up to
// the highest set one costs a squaring of the base register and, when set, a
// multiply of the accumulator by the base before it, each product with its
// own reduction. busy drops in the cycle after the beat. every product goes
// through one shared remainder unit that retires two dividend bits a cycle,
// and that unit sets the pace. the modulus register is reset to 3329 and may
// be written through the cfg channel whenever the block is idle; it is
// sampled when an item starts

module modular_exponentiation #(
  parameter int WORD_BITS = modexp_pkg::DEFAULT_WORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [modexp_pkg::DATA_W-1:0] base,
  input  logic [modexp_pkg::DATA_W-1:0] exponent,
  // result side, one beat per item
  output logic                          done,
  output logic [modexp_pkg::DATA_W-1:0] power_result,
  // modulus register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [modexp_pkg::DATA_W-1:0] cfg_data
);

  import modexp_pkg::*;

  logic [DATA_W-1:0]      modulus;
  ctl_t                   ctl;
  stat_t                  stat;
  logic [2*WORD_BITS-1:0] prod;
  logic [WORD_BITS-1:0]   m;
  logic                   red_start;
  logic                   red_done;
  logic [WORD_BITS-1:0]   red_r;

  // the register is always writable; the user keeps writes to idle periods
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RESET_MODULUS;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  // program counter and control store
  modexp_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  // operand registers and the one multiplier
  modexp_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .start        (start),
    .base         (base),
    .exponent     (exponent),
    .modulus      (modulus),
    .ctl          (ctl),
    .red_done     (red_done),
    .red_r        (red_r),
    .prod         (prod),
    .m            (m),
    .stat         (stat),
    .power_result (power_result)
  );

  // shared remainder unit, started once per product
  assign red_start = (ctl.act == ACT_RSTART);

  modexp_reduce #(
    .WORD_BITS (WORD_BITS)
  ) u_red (
    .clk   (clk),
    .rst   (rst),
    .start (red_start),
    .x     (prod),
    .m     (m),
    .done  (red_done),
    .r     (red_r)
  );

`ifndef SYNTHESIS
  // a result beat only comes out of a running item
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat while idle");

  // an accepted command starts work on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start");

  // exactly one beat per item, and the block is free right after it
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result beat repeated or block stuck");

  // the remainder unit never finishes outside a wait step
  a_red_wait: assert property (@(posedge clk) disable iff (rst)
    red_done |-> (ctl.cond == COND_NDONE))
    else $error("reduction finished with nobody waiting");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
  import modexp_pkg::*;

  typedef logic [DATA_W-1:0] word_t;

  // one outstanding item: what went in and the power it must produce
  typedef struct {
    word_t b;
    word_t e;
    word_t m;
    word_t power;
  } power_item_t;

  // keeps its own copy of the modulus register and a queue of the powers
  // that accepted items are owed, oldest first
  class power_scoreboard;
    word_t       modulus = RESET_MODULUS;
    power_item_t owed_powers[$];
    int unsigned failures = 0;

    // full double-width product folded back by the modulus; a zero modulus
    // is never written here, but would simply keep the low word
    function word_t fold(logic [2*DATA_W-1:0] x);
      if (modulus == '0) return x[DATA_W-1:0];
      return word_t'(x % modulus);
    endfunction

    // right-to-left square-and-multiply, base reduced first, accumulator
    // starts at one and is never reduced on its own
    function word_t mod_power(word_t b, word_t e);
      word_t               acc;
      word_t               run;
      logic [2*DATA_W-1:0] prod;
      acc = 1;
      run = fold({{DATA_W{1'b0}}, b});
      for (int i = 0; i < DATA_W; i++) begin
        if (e == '0) break;
        if (e[0]) begin
          prod = acc;
          prod = prod * run;
          acc  = fold(prod);
        end
        prod = run;
        prod = prod * run;
        run  = fold(prod);
        e    = e >> 1;
      end
      return acc;
    endfunction

    function void note_item(word_t b, word_t e);
      power_item_t it;
      it.b     = b;
      it.e     = e;
      it.m     = modulus;
      it.power = mod_power(b, e);
      owed_powers.insert(owed_powers.size(), it);
    endfunction

    function void check_result(word_t actual);
      power_item_t it;
      if (owed_powers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result beat with nothing owed: power_result=%h", actual);
        return;
      end
      it = owed_powers.pop_front();
      if (actual !== it.power) begin
        failures++;
        if (failures <= 10)
          $display("power_result wrong: base=%h exponent=%h modulus=%h expected=%h actual=%h",
                   it.b, it.e, it.m, it.power, actual);
      end
    endfunction

    function int pending();
      return owed_powers.size();
    endfunction
  endclass

  // every input starts at a known value, reset held from time zero
  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  start     = 1'b0;
  word_t base      = '0;
  word_t exponent  = '0;
  logic  cfg_valid = 1'b0;
  word_t cfg_data  = '0;
  logic  busy;
  logic  done;
  word_t power_result;
  logic  cfg_ready;

  power_scoreboard sb = new;

  // no idling on the command side in the closing stretch of the run
  bit calm = 1'b0;

  modular_exponentiation dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .base         (base),
    .exponent     (exponent),
    .done         (done),
    .power_result (power_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side cannot stall: every strobed beat is taken at the edge that
  // ends its cycle, so sample pre-edge values here
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(power_result);
  end

  // idle bursts before roughly a third of the beats,
  // which leaves long unbroken stretches as well
  function automatic int unsigned pick_gap();
    if (calm || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  // bases around the modulus and the word extremes, else anything
  function automatic word_t pick_base();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 1;
      2:       return sb.modulus - 1;
      3:       return sb.modulus;
      4:       return '1;
      5:       return sb.modulus * $urandom_range(2, 7);
      default: return $urandom;
    endcase
  endfunction

  // exponent length sets the run time, so most are short and a share full
  function automatic word_t pick_exponent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 1;
      2:       return '1;
      3, 4:    return $urandom_range(2, 255);
      5, 6:    return $urandom >> $urandom_range(8, 31);
      default: return $urandom;
    endcase
  endfunction

  // one command beat: held until the edge where start meets a low busy;
  // start is only ever written once per step
  task automatic send_item(word_t b, word_t e, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (busy);
    sb.note_item(b, e);
  endtask

  // every item owes exactly one result, so once the queue is empty and busy
  // is low the block is idle
  task automatic wait_drained();
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  // modulus is only changed while nothing is in flight
  task automatic write_modulus(word_t v);
    start <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.modulus = v;
  endtask

  initial begin
    word_t m;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset modulus first, untouched: zero cases, extremes, base equal to it
    send_item('0, '0, 0);
    send_item('0, 5, 0);
    send_item(1, '1, pick_gap());
    send_item(32'd3329, 1, 0);
    send_item('1, '1, 0);
    send_item('1, '0, pick_gap());
    send_item(2, 32'h8000_0000, 0);
    send_item(32'd3328, 2, 0);
    send_item(32'd12345, 1, 0);

    // modulus of one: zero exponent still gives one, anything else zero
    write_modulus(1);
    send_item(7, '0, 0);
    send_item(7, 5, 0);
    send_item('1, '1, 0);
    send_item('0, '0, pick_gap());

    // widest modulus: products use the full double width
    write_modulus('1);
    send_item('1, 3, 0);
    send_item(32'hFFFF_FFFE, '1, 0);
    send_item(32'hFFFF_FFFE, 2, 0);
    send_item(32'h8000_0000, 2, 0);

    write_modulus(2);
    send_item(3, '1, 0);
    send_item(4, 1, 0);

    // random phases, each under its own modulus, extremes among them
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       m = 1;
        1:       m = '1;
        2:       m = 32'h8000_0000;
        3:       m = 32'd65537;
        4:       m = RESET_MODULUS;
        default: m = $urandom_range(32'hFFFF_FFFF, 1);
      endcase
      write_modulus(m);
      calm = (p >= 7);
      for (int k = 0; k < 30; k++)
        send_item(pick_base(), pick_exponent(), pick_gap());
    end

    start <= 1'b0;
    wait_drained();
    // let any stray beat show itself before the verdict
    repeat (50) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog with ample margin over the worst case run
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
